// ===== sv/seam_pkg.sv =====
// package: constants, types and the square-root step function for the slope equal-area map
`default_nettype none
package seam_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 30;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 2 * OUT_FRAC_BITS + 1;
	localparam int COMP_LAT  = DIV_STEPS + SQ_STEPS + 1;
	localparam int TOTAL_LAT = 2 + SQ_STEPS + 1 + COMP_LAT;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] res;
	} sqst_t;

	typedef struct packed {
		logic [63:0] s;
		logic [4:0]  half;
		logic [62:0] ax;
		logic [62:0] ay;
		logic        nx;
		logic        ny;
	} side_t;

	function automatic sqst_t sqrt_step(sqst_t cur, int idx);
		sqst_t       nxt;
		logic [63:0] b;
		logic [63:0] trial;
		b = 64'd1 << (62 - 2 * idx);
		trial = cur.res + b;
		if (cur.rem >= trial) begin
			nxt.rem = cur.rem - trial;
			nxt.res = (cur.res >> 1) + b;
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

// ===== sv/seam_in_if.sv =====
// interface: input slope pair channel
`default_nettype none
interface seam_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_slope;
	logic [31:0] y_slope;

	modport source (output valid, output x_slope, output y_slope, input ready);
	modport sink (input valid, input x_slope, input y_slope, output ready);
endinterface
`default_nettype wire

// ===== sv/seam_out_if.sv =====
// interface: mapped coordinate pair channel
`default_nettype none
interface seam_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_mapped;
	logic [31:0] y_mapped;

	modport source (output valid, output x_mapped, output y_mapped, input ready);
	modport sink (input valid, input x_mapped, input y_mapped, output ready);
endinterface
`default_nettype wire

// ===== sv/seam_comp.sv =====
// one component: pipelined fraction divider, pipelined square root, sign restore
`default_nettype none
module seam_comp (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [62:0] a,
	input  wire logic [63:0] t,
	input  wire logic        neg,
	output logic      [31:0] mapped
);

	localparam int DS = seam_pkg::DIV_STEPS;
	localparam int SS = seam_pkg::SQ_STEPS;

	logic [63:0]   div_rem_s [1:DS];
	logic [DS-1:0] div_quo_s [1:DS];
	logic [63:0]   div_t_s   [1:DS];
	logic          div_neg_s [1:DS];

	seam_pkg::sqst_t sq_s     [1:SS];
	logic            sq_neg_s [1:SS];

	logic [31:0] out_s;

	genvar i;
	generate
		for (i = 1; i <= DS; i++) begin : g_div
			logic [63:0]   rem_c;
			logic [DS-1:0] quo_c;
			logic [63:0]   t_c;
			logic          neg_c;
			logic [64:0]   two;
			if (i == 1) begin : g_first
				assign rem_c = {1'b0, a};
				assign quo_c = '0;
				assign t_c   = t;
				assign neg_c = neg;
			end else begin : g_next
				assign rem_c = div_rem_s[i-1];
				assign quo_c = div_quo_s[i-1];
				assign t_c   = div_t_s[i-1];
				assign neg_c = div_neg_s[i-1];
			end
			assign two = {rem_c, 1'b0};
			always_ff @(posedge clk) begin
				if (en) begin
					if (two >= {1'b0, t_c}) begin
						div_rem_s[i] <= 64'(two - {1'b0, t_c});
						div_quo_s[i] <= {quo_c[DS-2:0], 1'b1};
					end else begin
						div_rem_s[i] <= two[63:0];
						div_quo_s[i] <= {quo_c[DS-2:0], 1'b0};
					end
					div_t_s[i]   <= t_c;
					div_neg_s[i] <= neg_c;
				end
			end
		end

		for (i = 1; i <= SS; i++) begin : g_sq
			seam_pkg::sqst_t cur_c;
			logic            neg_c;
			if (i == 1) begin : g_first
				assign cur_c.rem = 64'(div_quo_s[DS]);
				assign cur_c.res = '0;
				assign neg_c     = div_neg_s[DS];
			end else begin : g_next
				assign cur_c = sq_s[i-1];
				assign neg_c = sq_neg_s[i-1];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					sq_s[i]     <= seam_pkg::sqrt_step(cur_c, i - 1);
					sq_neg_s[i] <= neg_c;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= sq_neg_s[SS] ? 32'(-sq_s[SS].res[31:0]) : sq_s[SS].res[31:0];
		end
	end

	assign mapped = out_s;

endmodule
`default_nettype wire

// ===== sv/slope_equal_area_map.sv =====
// top level: equal-area mapping of a slope pair, fully pipelined
// throughput: one transaction per cycle whenever map_out is not stalled;
// set by the one-step-per-stage root and divider chains
// a stalled output holds the whole pipeline, nothing is lost or repeated
// reset clears the stage valid bits only; data registers are not reset
`default_nettype none
module slope_equal_area_map (
	input  wire logic clk,
	input  wire logic arst_n,
	seam_in_if.sink   slope_in,
	seam_out_if.source map_out
);

	localparam int SS  = seam_pkg::SQ_STEPS;
	localparam int LAT = seam_pkg::TOTAL_LAT;
	localparam int F   = seam_pkg::IN_FRAC_BITS;

	logic [LAT-1:0] vld_q;
	logic           en;

	assign en             = !vld_q[LAT-1] || map_out.ready;
	assign slope_in.ready = en;
	assign map_out.valid  = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], slope_in.valid};
		end
	end

	// stage 1: magnitudes and squares
	logic [31:0] mx, my;
	logic        nx_s1, ny_s1;
	logic [62:0] ax_s1, ay_s1;

	assign mx = slope_in.x_slope[31] ? 32'(-slope_in.x_slope) : slope_in.x_slope;
	assign my = slope_in.y_slope[31] ? 32'(-slope_in.y_slope) : slope_in.y_slope;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= slope_in.x_slope[31];
			ny_s1 <= slope_in.y_slope[31];
			ax_s1 <= 63'(64'(mx) * 64'(mx));
			ay_s1 <= 63'(64'(my) * 64'(my));
		end
	end

	// stage 2: sum and normalizing shift
	logic [63:0]      s_c;
	logic [4:0]       half_c;
	seam_pkg::side_t  sd_s2;

	assign s_c = (64'd1 << (2 * F)) + 64'(ax_s1) + 64'(ay_s1);

	always_comb begin
		half_c = 5'd31;
		for (int k = 30; k >= 0; k--) begin
			if (s_c[63-2*k -: 2] != 2'b00) half_c = 5'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2.s    <= s_c;
			sd_s2.half <= half_c;
			sd_s2.ax   <= ax_s1;
			sd_s2.ay   <= ay_s1;
			sd_s2.nx   <= nx_s1;
			sd_s2.ny   <= ny_s1;
		end
	end

	// root of the normalized sum
	seam_pkg::sqst_t rt_s [1:SS];
	seam_pkg::side_t sd_s [1:SS];

	genvar i;
	generate
		for (i = 1; i <= SS; i++) begin : g_rt
			seam_pkg::sqst_t cur_c;
			seam_pkg::side_t side_c;
			if (i == 1) begin : g_first
				assign cur_c.rem = sd_s2.s << {sd_s2.half, 1'b0};
				assign cur_c.res = '0;
				assign side_c    = sd_s2;
			end else begin : g_next
				assign cur_c  = rt_s[i-1];
				assign side_c = sd_s[i-1];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rt_s[i] <= seam_pkg::sqrt_step(cur_c, i - 1);
					sd_s[i] <= side_c;
				end
			end
		end
	endgenerate

	// denominator stage
	logic [31:0] p_c;
	logic [63:0] w_c;
	logic [63:0] t_st;
	logic [62:0] ax_st, ay_st;
	logic        nx_st, ny_st;

	assign p_c = rt_s[SS].res[31:0];
	assign w_c = (int'(sd_s[SS].half) <= F)
		? (64'(p_c) << (F - int'(sd_s[SS].half)))
		: (64'(p_c) >> (int'(sd_s[SS].half) - F));

	always_ff @(posedge clk) begin
		if (en) begin
			t_st  <= sd_s[SS].s + w_c;
			ax_st <= sd_s[SS].ax;
			ay_st <= sd_s[SS].ay;
			nx_st <= sd_s[SS].nx;
			ny_st <= sd_s[SS].ny;
		end
	end

	seam_comp u_comp_x (
		.clk    (clk),
		.en     (en),
		.a      (ax_st),
		.t      (t_st),
		.neg    (nx_st),
		.mapped (map_out.x_mapped)
	);

	seam_comp u_comp_y (
		.clk    (clk),
		.en     (en),
		.a      (ay_st),
		.t      (t_st),
		.neg    (ny_st),
		.mapped (map_out.y_mapped)
	);

endmodule
`default_nettype wire
